FILE: sv/sptme_pkg.sv
`default_nettype none

package sptme_pkg;

  // Action codes carried on the input beat
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_MERGE  = 2'd1;
  localparam logic [1:0] ACT_EVAL   = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam int unsigned COEF_W = 32;
  localparam int unsigned EXP_W  = 4;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned NUM_POW = 1 << EXP_W;

  // One stored term: coefficient and three exponents (44 bits)
  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic [EXP_W-1:0]  ex;
    logic [EXP_W-1:0]  ey;
    logic [EXP_W-1:0]  ez;
  } term_t;

  typedef logic [COEF_W-1:0] word_t;

endpackage

`default_nettype wire

FILE: sv/sparse_poly_term_merge_eval.sv
`default_nettype none

// Channel   Direction  Beat contents
// --------  ---------  ------------------------------------------------------
// in_       input      action, coefficient, exp_x/y/z, x/y/z_value
// out_      output     eval_result, status, term_count
//
// One item at a time; in_stall is high from the accepting edge until the result
// beat is loaded. Append and clear go straight to the result beat; merge reads
// and compares stored terms in turn until one matches or all are passed; evaluate
// builds the power tables, then does a read and three multiplies per term.
// rst_n (synchronous) empties the table and drops any pending result beat. A
// stalled result holds while the next item is worked on; only its last step waits.

module sparse_poly_term_merge_eval
  import sptme_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,

  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  [1:0]              in_action,
  input  wire  signed [31:0]      in_coefficient,
  input  wire  [3:0]              in_exp_x,
  input  wire  [3:0]              in_exp_y,
  input  wire  [3:0]              in_exp_z,
  input  wire  signed [15:0]      in_x_value,
  input  wire  signed [15:0]      in_y_value,
  input  wire  signed [15:0]      in_z_value,

  output logic                    out_valid,
  input  wire                     out_stall,
  output logic signed [31:0]      out_eval_result,
  output logic                    out_status,
  output logic [4:0]              out_term_count
);

  localparam int unsigned IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);

  // Sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_M_WAIT = 4'd1;  // merge: address set, data next
  localparam logic [3:0] S_M_CMP  = 4'd2;  // merge: compare exponents
  localparam logic [3:0] S_PRE    = 4'd3;  // evaluate: build power tables
  localparam logic [3:0] S_E_WAIT = 4'd4;  // evaluate: first term read
  localparam logic [3:0] S_E_M1   = 4'd5;  // coef * x^ex
  localparam logic [3:0] S_E_M2   = 4'd6;  // * y^ey
  localparam logic [3:0] S_E_M3   = 4'd7;  // * z^ez
  localparam logic [3:0] S_E_ACC  = 4'd8;  // accumulate
  localparam logic [3:0] S_FIN    = 4'd9;  // load result beat

  logic [3:0]        state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  idx_r;
  logic              out_valid_r;

  // Latched item
  logic [1:0]        act_r;
  word_t             coef_r;
  logic [EXP_W-1:0]  ex_r, ey_r, ez_r;
  word_t             xv_r, yv_r, zv_r;

  // Evaluate datapath
  word_t             xp_r [NUM_POW];
  word_t             yp_r [NUM_POW];
  word_t             zp_r [NUM_POW];
  word_t             pwx_r, pwy_r, pwz_r;
  logic [EXP_W-1:0]  pre_k_r;
  word_t             prod_r;
  word_t             acc_r;
  logic [EXP_W-1:0]  tey_r, tez_r;
  logic              status_r;

  // Term table
  term_t             term_mem [MAX_TERMS];
  term_t             rd_data_r;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  term_t             wr_data;

  logic              in_acc;
  logic              room;
  logic              match;
  logic              out_free;
  logic              out_load;
  logic [CNT_W+4:0]  cnt_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign room      = (cnt_r < CNT_W'(MAX_TERMS));
  assign match     = (rd_data_r.ex == ex_r) && (rd_data_r.ey == ey_r) &&
                     (rd_data_r.ez == ez_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_FIN) && out_free;
  assign out_valid = out_valid_r;
  assign cnt_ext   = {5'b0, cnt_r};

  // Write port: append at the fill point, or merge into a matching entry
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[IDX_W-1:0];
    wr_data = term_t'{coef: coef_r, ex: ex_r, ey: ey_r, ez: ez_r};
    unique case (state_r)
      S_IDLE: begin
        wr_en   = in_acc && (in_action == ACT_APPEND) && room;
        wr_data = term_t'{coef: word_t'(in_coefficient), ex: in_exp_x,
                          ey: in_exp_y, ez: in_exp_z};
      end
      S_M_WAIT: begin
        wr_en = (idx_r == cnt_r) && room;
      end
      S_M_CMP: begin
        wr_en        = match;
        wr_addr      = idx_r[IDX_W-1:0];
        wr_data.coef = rd_data_r.coef + coef_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      term_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= term_mem[idx_r[IDX_W-1:0]];
  end

  // Power tables: one running product per variable, written one row a cycle
  always_ff @(posedge clk) begin
    if (state_r == S_PRE) begin
      xp_r[pre_k_r] <= pwx_r;
      yp_r[pre_k_r] <= pwy_r;
      zp_r[pre_k_r] <= pwz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a fresh result beat, or drop the current one once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            act_r    <= in_action;
            coef_r   <= word_t'(in_coefficient);
            ex_r     <= in_exp_x;
            ey_r     <= in_exp_y;
            ez_r     <= in_exp_z;
            xv_r     <= word_t'(in_x_value);
            yv_r     <= word_t'(in_y_value);
            zv_r     <= word_t'(in_z_value);
            idx_r    <= '0;
            acc_r    <= '0;
            status_r <= 1'b0;
            pwx_r    <= word_t'(1);
            pwy_r    <= word_t'(1);
            pwz_r    <= word_t'(1);
            pre_k_r  <= '0;
            unique case (in_action)
              ACT_APPEND: begin
                if (room) begin
                  cnt_r <= cnt_r + CNT_W'(1);
                end else begin
                  status_r <= 1'b1;
                end
                state_r <= S_FIN;
              end
              ACT_MERGE: begin
                state_r <= S_M_WAIT;
              end
              ACT_EVAL: begin
                state_r <= S_PRE;
              end
              ACT_CLEAR: begin
                cnt_r   <= '0;
                state_r <= S_FIN;
              end
            endcase
          end
        end

        S_M_WAIT: begin
          if (idx_r == cnt_r) begin
            // No match anywhere: append, or flag a full table
            if (room) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end else begin
              status_r <= 1'b1;
            end
            state_r <= S_FIN;
          end else begin
            state_r <= S_M_CMP;
          end
        end

        S_M_CMP: begin
          if (match) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= S_M_WAIT;
          end
        end

        S_PRE: begin
          pwx_r   <= pwx_r * xv_r;
          pwy_r   <= pwy_r * yv_r;
          pwz_r   <= pwz_r * zv_r;
          pre_k_r <= pre_k_r + EXP_W'(1);
          if (pre_k_r == EXP_W'(NUM_POW - 1)) begin
            state_r <= S_E_WAIT;
          end
        end

        S_E_WAIT: begin
          state_r <= (cnt_r == '0) ? S_FIN : S_E_M1;
        end

        S_E_M1: begin
          prod_r  <= rd_data_r.coef * xp_r[rd_data_r.ex];
          tey_r   <= rd_data_r.ey;
          tez_r   <= rd_data_r.ez;
          // Advance the read address; next term is ready by S_E_ACC
          idx_r   <= idx_r + CNT_W'(1);
          state_r <= S_E_M2;
        end

        S_E_M2: begin
          prod_r  <= prod_r * yp_r[tey_r];
          state_r <= S_E_M3;
        end

        S_E_M3: begin
          prod_r  <= prod_r * zp_r[tez_r];
          state_r <= S_E_ACC;
        end

        S_E_ACC: begin
          acc_r   <= acc_r + prod_r;
          state_r <= (idx_r == cnt_r) ? S_FIN : S_E_M1;
        end

        S_FIN: begin
          // Hold until the output register is free
          if (out_free) begin
            out_eval_result <= (act_r == ACT_EVAL) ? acc_r : '0;
            out_status      <= status_r;
            out_term_count  <= cnt_ext[4:0];
            state_r         <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
